>>> hw/rtl/version_string_parser_macros.svh
// Assertion macros shared by the version string parser modules.
`ifndef VERSION_STRING_PARSER_MACROS_SVH
`define VERSION_STRING_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle check: when ante holds, cons must hold.
`define VSP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the following cycle.
`define VSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define VSP_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define VSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

>>> hw/rtl/vsp_pkg.sv
// Types, constants and codes shared by the version string parser.
package vsp_pkg;

    localparam int MAX_DIGITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 4;

    localparam int ACC_W   = 63;
    localparam int FIELD_W = 31;
    localparam int TYPE_W  = 3;
    localparam int COUNT_W = 16;
    localparam int CHAR_W  = 8;

    // Build type codes
    localparam logic [TYPE_W-1:0] BT_UNKNOWN    = 3'd0;
    localparam logic [TYPE_W-1:0] BT_TEST       = 3'd1;
    localparam logic [TYPE_W-1:0] BT_DEBUG      = 3'd2;
    localparam logic [TYPE_W-1:0] BT_ALPHA      = 3'd3;
    localparam logic [TYPE_W-1:0] BT_BETA       = 3'd4;
    localparam logic [TYPE_W-1:0] BT_PRERELEASE = 3'd5;
    localparam logic [TYPE_W-1:0] BT_RELEASE    = 3'd6;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h42;
    localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
    localparam logic [CHAR_W-1:0] CH_R     = 8'h52;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;

    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_LETTER,
        TK_DOT,
        TK_DASH,
        TK_BLANK,
        TK_TERM,
        TK_ILLEGAL
    } tok_cls_t;

    typedef struct packed {
        tok_cls_t   cls;
        logic [3:0] val;   // digit value, or build type code for a letter
        logic       last;
    } token_t;

    typedef enum logic [2:0] {
        PH_MAJOR,
        PH_MINOR,
        PH_PATCH,
        PH_TYPE,
        PH_ID
    } phase_t;

endpackage

>>> hw/rtl/vsp_front.sv
// Front end: accept characters and classify them into tokens.
module vsp_front
    import vsp_pkg::*;
(
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_character,
    input  logic              s_last,
    input  logic              q_full,
    output logic              q_push,
    output token_t            q_token
);

    logic [CHAR_W-1:0] digit_off;

    assign digit_off = s_character - CH_ZERO;
    assign s_ready   = aresetn && !q_full;
    assign q_push    = s_valid && s_ready;

    always_comb begin
        q_token.last = s_last;
        q_token.val  = 4'd0;
        if (s_character >= CH_ZERO && s_character <= CH_NINE) begin
            q_token.cls = TK_DIGIT;
            q_token.val = digit_off[3:0];
        end else begin
            unique case (s_character)
                CH_T:     begin q_token.cls = TK_LETTER; q_token.val = {1'b0, BT_TEST}; end
                CH_D:     begin q_token.cls = TK_LETTER; q_token.val = {1'b0, BT_DEBUG}; end
                CH_A:     begin q_token.cls = TK_LETTER; q_token.val = {1'b0, BT_ALPHA}; end
                CH_B:     begin q_token.cls = TK_LETTER; q_token.val = {1'b0, BT_BETA}; end
                CH_P:     begin
                    q_token.cls = TK_LETTER;
                    q_token.val = {1'b0, BT_PRERELEASE};
                end
                CH_R:     begin q_token.cls = TK_LETTER; q_token.val = {1'b0, BT_RELEASE}; end
                CH_DOT:   q_token.cls = TK_DOT;
                CH_DASH:  q_token.cls = TK_DASH;
                CH_SPACE: q_token.cls = TK_BLANK;
                CH_TAB:   q_token.cls = TK_BLANK;
                CH_NUL:   q_token.cls = TK_TERM;
                CH_HASH:  q_token.cls = TK_TERM;
                CH_CR:    q_token.cls = TK_TERM;
                CH_LF:    q_token.cls = TK_TERM;
                CH_RPAR:  q_token.cls = TK_TERM;
                default:  q_token.cls = TK_ILLEGAL;
            endcase
        end
    end

endmodule

>>> hw/rtl/vsp_queue.sv
// Short token queue between the front end and the back end.
`include "version_string_parser_macros.svh"

module vsp_queue
    import vsp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  token_t push_token,
    output logic   full,
    output logic   out_valid,
    input  logic   pop,
    output token_t out_token
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    token_t        mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_token = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_token;
        end
    end

    `VSP_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(QUEUE_DEPTH), "queue count above depth")
    `VSP_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == CW'($past(count_reg) + 1'b1), "queue count missed a push")
    `VSP_ASSERT_NEXT(a_count_down, aclk, aresetn, pop && !push, count_reg == CW'($past(count_reg) - 1'b1), "queue count missed a pop")

endmodule

>>> hw/rtl/vsp_back.sv
// Back end: field state, decimal accumulation and the result register.
`include "version_string_parser_macros.svh"

module vsp_back
    import vsp_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               tok_valid,
    input  token_t             tok,
    output logic               tok_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic [FIELD_W-1:0] m_major,
    output logic [FIELD_W-1:0] m_minor,
    output logic [FIELD_W-1:0] m_patch,
    output logic [TYPE_W-1:0]  m_build_type,
    output logic [ACC_W-1:0]   m_build_id,
    output logic [COUNT_W-1:0] m_consumed
);

    localparam int DCW  = $clog2(MAX_DIGITS + 1);
    localparam int EXTW = ACC_W + 4;

    phase_t             phase_reg, phase_next;
    logic [DCW-1:0]     dc_reg, dc_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [FIELD_W-1:0] major_reg, major_next;
    logic [FIELD_W-1:0] minor_reg, minor_next;
    logic [FIELD_W-1:0] patch_reg, patch_next;
    logic [TYPE_W-1:0]  type_reg, type_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               skipping_reg, skipping_next;

    logic               m_valid_reg;
    logic               status_reg;
    logic [FIELD_W-1:0] o_major_reg, o_minor_reg, o_patch_reg;
    logic [TYPE_W-1:0]  o_type_reg;
    logic [ACC_W-1:0]   o_id_reg;
    logic [COUNT_W-1:0] o_cnt_reg;

    logic               res_fire;
    logic               r_status;
    logic [FIELD_W-1:0] r_major, r_minor, r_patch;
    logic [TYPE_W-1:0]  r_type;
    logic [ACC_W-1:0]   r_id;
    logic [COUNT_W-1:0] r_cnt;

    logic [EXTW-1:0]    acc_ext, acc_times10;
    logic [ACC_W-1:0]   acc_digit;
    logic [FIELD_W-1:0] acc_sat31;

    // acc*10 + d, saturated at the 63-bit maximum
    assign acc_ext     = {4'd0, acc_reg};
    assign acc_times10 = (acc_ext << 3) + (acc_ext << 1) + EXTW'(tok.val);
    assign acc_digit   = (acc_times10[EXTW-1:ACC_W] != '0) ? '1 : acc_times10[ACC_W-1:0];
    assign acc_sat31   = (acc_reg[ACC_W-1:FIELD_W] != '0) ? '1 : acc_reg[FIELD_W-1:0];

    assign tok_pop = tok_valid && (!m_valid_reg || m_ready);

    always_comb begin
        logic fail;
        logic ended;
        phase_t             w_phase;
        logic [DCW-1:0]     w_dc;
        logic [ACC_W-1:0]   w_acc;
        logic [FIELD_W-1:0] w_major, w_minor, w_patch;
        logic [TYPE_W-1:0]  w_type;
        logic [COUNT_W-1:0] w_cnt;
        logic               count_one;

        fail      = 1'b0;
        ended     = 1'b0;
        count_one = 1'b0;
        w_phase   = phase_reg;
        w_dc      = dc_reg;
        w_acc     = acc_reg;
        w_major   = major_reg;
        w_minor   = minor_reg;
        w_patch   = patch_reg;
        w_type    = type_reg;
        w_cnt     = cnt_reg;

        res_fire = 1'b0;
        r_status = 1'b0;
        r_major  = '0;
        r_minor  = '0;
        r_patch  = '0;
        r_type   = BT_UNKNOWN;
        r_id     = '0;
        r_cnt    = '0;

        phase_next    = phase_reg;
        dc_next       = dc_reg;
        acc_next      = acc_reg;
        major_next    = major_reg;
        minor_next    = minor_reg;
        patch_next    = patch_reg;
        type_next     = type_reg;
        cnt_next      = cnt_reg;
        skipping_next = skipping_reg;

        if (tok_pop && !skipping_reg) begin
            unique case (tok.cls)
                TK_DIGIT: begin
                    if (dc_reg >= DCW'(MAX_DIGITS)) begin
                        fail = 1'b1;
                    end else begin
                        w_acc     = acc_digit;
                        w_dc      = dc_reg + 1'b1;
                        count_one = 1'b1;
                    end
                end
                TK_LETTER: begin
                    if (phase_reg != PH_TYPE) begin
                        fail = 1'b1;
                    end else begin
                        w_type    = tok.val[TYPE_W-1:0];
                        w_phase   = PH_ID;
                        count_one = 1'b1;
                    end
                end
                TK_DOT: begin
                    if (dc_reg == '0 || phase_reg == PH_TYPE || phase_reg == PH_ID) begin
                        fail = 1'b1;
                    end else begin
                        unique case (phase_reg)
                            PH_MAJOR: begin w_major = acc_sat31; w_phase = PH_MINOR; end
                            PH_MINOR: begin w_minor = acc_sat31; w_phase = PH_PATCH; end
                            default:  begin w_patch = acc_sat31; w_phase = PH_TYPE; end
                        endcase
                        w_acc     = '0;
                        w_dc      = '0;
                        count_one = 1'b1;
                    end
                end
                TK_DASH: begin
                    if (phase_reg != PH_PATCH) begin
                        fail = 1'b1;
                    end else begin
                        w_patch   = acc_sat31;
                        w_acc     = '0;
                        w_dc      = '0;
                        w_phase   = PH_TYPE;
                        count_one = 1'b1;
                    end
                end
                TK_BLANK: begin
                    if (phase_reg == PH_MAJOR && dc_reg == '0) begin
                        count_one = 1'b1;
                    end else begin
                        ended = 1'b1;
                    end
                end
                TK_TERM: ended = 1'b1;
                default: fail = 1'b1;
            endcase

            if (count_one && cnt_reg != '1) begin
                w_cnt = cnt_reg + 1'b1;
            end
            if (!fail && !ended && tok.last) begin
                ended = 1'b1;
            end
            // a string with no major digit is an error
            if (ended && w_phase == PH_MAJOR && w_dc == '0) begin
                ended = 1'b0;
                fail  = 1'b1;
            end

            res_fire = fail || ended;
            if (fail) begin
                r_status = 1'b1;
            end else begin
                r_major = w_major;
                r_minor = w_minor;
                r_patch = w_patch;
                r_cnt   = w_cnt;
                unique case (w_phase)
                    PH_MAJOR: r_major = (w_acc[ACC_W-1:FIELD_W] != '0) ? '1 : w_acc[FIELD_W-1:0];
                    PH_MINOR: r_minor = (w_acc[ACC_W-1:FIELD_W] != '0) ? '1 : w_acc[FIELD_W-1:0];
                    PH_PATCH: r_patch = (w_acc[ACC_W-1:FIELD_W] != '0) ? '1 : w_acc[FIELD_W-1:0];
                    PH_ID: begin
                        r_type = w_type;
                        r_id   = w_acc;
                    end
                    default: ;
                endcase
            end

            phase_next = w_phase;
            dc_next    = w_dc;
            acc_next   = w_acc;
            major_next = w_major;
            minor_next = w_minor;
            patch_next = w_patch;
            type_next  = w_type;
            cnt_next   = w_cnt;
            if (res_fire && !tok.last) begin
                skipping_next = 1'b1;
            end
        end

        // the last byte of a buffer always starts over
        if (tok_pop && tok.last) begin
            phase_next    = PH_MAJOR;
            dc_next       = '0;
            acc_next      = '0;
            major_next    = '0;
            minor_next    = '0;
            patch_next    = '0;
            type_next     = BT_UNKNOWN;
            cnt_next      = '0;
            skipping_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_MAJOR;
            dc_reg       <= '0;
            acc_reg      <= '0;
            major_reg    <= '0;
            minor_reg    <= '0;
            patch_reg    <= '0;
            type_reg     <= BT_UNKNOWN;
            cnt_reg      <= '0;
            skipping_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            dc_reg       <= dc_next;
            acc_reg      <= acc_next;
            major_reg    <= major_next;
            minor_reg    <= minor_next;
            patch_reg    <= patch_next;
            type_reg     <= type_next;
            cnt_reg      <= cnt_next;
            skipping_reg <= skipping_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_fire) begin
            status_reg  <= r_status;
            o_major_reg <= r_major;
            o_minor_reg <= r_minor;
            o_patch_reg <= r_patch;
            o_type_reg  <= r_type;
            o_id_reg    <= r_id;
            o_cnt_reg   <= r_cnt;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_major      = o_major_reg;
    assign m_minor      = o_minor_reg;
    assign m_patch      = o_patch_reg;
    assign m_build_type = o_type_reg;
    assign m_build_id   = o_id_reg;
    assign m_consumed   = o_cnt_reg;

    `VSP_ASSERT_NOW(a_slot_free, aclk, aresetn, res_fire, !m_valid_reg || m_ready, "result overwrote a pending result")
    `VSP_ASSERT_NEXT(a_last_clears, aclk, aresetn, tok_pop && tok.last, !skipping_reg && phase_reg == PH_MAJOR && dc_reg == '0 && cnt_reg == '0, "last byte did not clear state")
    `VSP_ASSERT_NOW(a_id_has_type, aclk, aresetn, phase_reg == PH_ID, type_reg != BT_UNKNOWN, "build id phase without a build type")

endmodule

>>> hw/rtl/version_string_parser.sv
// Version string parser: one character per transaction in, one result per string out.
// A result passes through the token queue and then the result register before m_valid rises.
// Throughput: one character per cycle while the token queue is not full; classify is
// combinational in the front end, the back end does the multiply-by-ten accumulate per token,
// and a four-entry token queue absorbs output stalls.
// Reset: synchronous, active-low aresetn empties the queue, drops any result, clears field state.
module version_string_parser
    import vsp_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // character channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CHAR_W-1:0]  s_character,
    input  logic               s_last,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic [FIELD_W-1:0] m_major,
    output logic [FIELD_W-1:0] m_minor,
    output logic [FIELD_W-1:0] m_patch,
    output logic [TYPE_W-1:0]  m_build_type,
    output logic [ACC_W-1:0]   m_build_id,
    output logic [COUNT_W-1:0] m_consumed
);

    // Front end to queue
    logic   q_push;
    logic   q_full;
    token_t q_in_token;

    // Queue to back end
    logic   q_valid;
    logic   q_pop;
    token_t q_out_token;

    // Classify each accepted character into a token; hold off while the queue is full.
    vsp_front u_front (
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .s_last      (s_last),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_token     (q_in_token)
    );

    // Buffer tokens so the input keeps flowing while a result waits to be taken.
    vsp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_token (q_in_token),
        .full       (q_full),
        .out_valid  (q_valid),
        .pop        (q_pop),
        .out_token  (q_out_token)
    );

    // Advance field state one token per cycle while no result waits; register one per string.
    vsp_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tok_valid    (q_valid),
        .tok          (q_out_token),
        .tok_pop      (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_major      (m_major),
        .m_minor      (m_minor),
        .m_patch      (m_patch),
        .m_build_type (m_build_type),
        .m_build_id   (m_build_id),
        .m_consumed   (m_consumed)
    );

endmodule
